// ===== design/sldf_pkg.sv =====
// Shared types and constants for the sync/length frame deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sldf_pkg;

  localparam logic [7:0]  SYNC_BYTE     = 8'hFE;
  localparam logic [7:0]  STUFF_BYTE    = 8'h5A;
  localparam logic [15:0] SYNC_PAIR_SUM = 16'h01FC;
  localparam logic [15:0] MIN_BODY_LEN  = 16'd4;
  localparam logic [15:0] MAX_BODY_LEN_RESET = 16'd260;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_ABORT    = 2'd2;
  localparam logic [1:0] ST_BAD_LEN  = 2'd3;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  payload_byte;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [1:0]  status;
    logic [15:0] payload_count;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== design/sldf_front.sv =====
// Front end: sync hunt, unstuffing, length check, checksum and result classification.
// Depends on sldf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sldf_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             byte_we,
  input  wire logic [7:0]       in_byte,
  output logic                  push,
  output sldf_pkg::item_t       item
);

  localparam logic [2:0] PH_HUNT1 = 3'd0;
  localparam logic [2:0] PH_HUNT2 = 3'd1;
  localparam logic [2:0] PH_LENH  = 3'd2;
  localparam logic [2:0] PH_LENL  = 3'd3;
  localparam logic [2:0] PH_BODY  = 3'd4;

  logic [15:0] max_body_len;
  logic [2:0]  phase, phase_next;
  logic        esc, esc_next;
  logic [15:0] blen, blen_next;
  logic [15:0] bcnt, bcnt_next;
  logic [15:0] sum, sum_next;
  logic [7:0]  cmd, cmd_next;
  logic [7:0]  seq, seq_next;
  logic [7:0]  ckh, ckh_next;

  logic        emit;
  logic        do_take;
  logic        sync_hit;
  logic        body_abort;
  logic [7:0]  d;
  logic [15:0] len_lo;
  logic [15:0] len_m2;
  logic [15:0] got;
  logic [15:0] lim;
  logic [15:0] abort_cnt;

  assign len_lo = {blen[15:8], d};
  assign len_m2 = blen - 16'd2;
  assign got    = (bcnt > 16'd2) ? bcnt - 16'd2 : 16'd0;
  assign lim    = (blen >= sldf_pkg::MIN_BODY_LEN) ? blen - sldf_pkg::MIN_BODY_LEN : 16'd0;
  assign abort_cnt = (got > lim) ? lim : got;

  always_comb begin
    phase_next = phase;
    esc_next   = esc;
    blen_next  = blen;
    bcnt_next  = bcnt;
    sum_next   = sum;
    cmd_next   = cmd;
    seq_next   = seq;
    ckh_next   = ckh;
    emit       = 1'b0;
    item       = '0;
    do_take    = 1'b0;
    sync_hit   = 1'b0;
    body_abort = 1'b0;
    d          = in_byte;

    case (phase)
      PH_HUNT1: begin
        if (in_byte == sldf_pkg::SYNC_BYTE) phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (in_byte == sldf_pkg::SYNC_BYTE) sync_hit = 1'b1;
        else phase_next = PH_HUNT1;
      end
      PH_LENH, PH_LENL, PH_BODY: begin
        if (esc) begin
          esc_next = 1'b0;
          if (in_byte == sldf_pkg::STUFF_BYTE) begin
            do_take = 1'b1;
            d       = sldf_pkg::SYNC_BYTE;
          end else if (in_byte == sldf_pkg::SYNC_BYTE) begin
            sync_hit   = 1'b1;
            body_abort = (phase == PH_BODY);
          end else if (phase == PH_LENH) begin
            do_take = 1'b1;
          end else begin
            body_abort = (phase == PH_BODY);
            phase_next = PH_HUNT1;
          end
        end else if (in_byte == sldf_pkg::SYNC_BYTE) begin
          esc_next = 1'b1;
        end else begin
          do_take = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HUNT1;
      end
    endcase

    if (body_abort) begin
      emit               = 1'b1;
      item.is_end        = 1'b1;
      item.command       = cmd;
      item.sequence_res  = seq;
      item.status        = sldf_pkg::ST_ABORT;
      item.payload_count = abort_cnt;
    end

    if (sync_hit) begin
      phase_next = PH_LENH;
      esc_next   = 1'b0;
      sum_next   = sldf_pkg::SYNC_PAIR_SUM;
      blen_next  = '0;
      bcnt_next  = '0;
      cmd_next   = '0;
      seq_next   = '0;
      ckh_next   = '0;
    end

    if (do_take) begin
      case (phase)
        PH_LENH: begin
          blen_next  = {d, 8'h00};
          sum_next   = sum + {8'h00, d};
          phase_next = PH_LENL;
        end
        PH_LENL: begin
          blen_next = len_lo;
          sum_next  = sum + {8'h00, d};
          if (len_lo < sldf_pkg::MIN_BODY_LEN || len_lo > max_body_len) begin
            emit        = 1'b1;
            item.is_end = 1'b1;
            item.status = sldf_pkg::ST_BAD_LEN;
            phase_next  = PH_HUNT1;
          end else begin
            bcnt_next  = '0;
            phase_next = PH_BODY;
          end
        end
        default: begin
          bcnt_next = bcnt + 16'd1;
          if (bcnt == 16'd0) begin
            cmd_next = d;
            sum_next = sum + {8'h00, d};
          end else if (bcnt == 16'd1) begin
            seq_next = d;
            sum_next = sum + {8'h00, d};
          end else if (bcnt < len_m2) begin
            sum_next          = sum + {8'h00, d};
            emit              = 1'b1;
            item.payload_byte = d;
            item.command      = cmd;
            item.sequence_res = seq;
          end else if (bcnt == len_m2) begin
            ckh_next = d;
          end else begin
            emit               = 1'b1;
            item.is_end        = 1'b1;
            item.command       = cmd;
            item.sequence_res  = seq;
            item.status        = ({ckh, d} == sum) ? sldf_pkg::ST_OK
                                                   : sldf_pkg::ST_CHECKSUM;
            item.payload_count = blen - sldf_pkg::MIN_BODY_LEN;
            phase_next         = PH_HUNT1;
          end
        end
      endcase
    end
  end

  assign push = byte_we & emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_len <= sldf_pkg::MAX_BODY_LEN_RESET;
      phase        <= PH_HUNT1;
      esc          <= 1'b0;
      blen         <= '0;
      bcnt         <= '0;
      sum          <= '0;
      cmd          <= '0;
      seq          <= '0;
      ckh          <= '0;
    end else begin
      if (cfg_we) max_body_len <= cfg_data;
      if (byte_we) begin
        phase <= phase_next;
        esc   <= esc_next;
        blen  <= blen_next;
        bcnt  <= bcnt_next;
        sum   <= sum_next;
        cmd   <= cmd_next;
        seq   <= seq_next;
        ckh   <= ckh_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sldf_queue.sv =====
// Short result queue between the front end and the output stage.
// Depends on sldf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sldf_queue #(
  parameter int DEPTH = sldf_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sldf_pkg::item_t  wr_item,
  input  wire logic             pop,
  output sldf_pkg::item_t       rd_item,
  output sldf_pkg::queue_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sldf_pkg::item_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign rd_item    = mem[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/sldf_back.sv =====
// Output stage: registers one result word and hands it out on a valid/ready channel.
// Depends on sldf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sldf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sldf_pkg::item_t  q_item,
  input  wire logic             q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sldf_pkg::item_t       out_item
);

  assign pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_item <= q_item;
  end

endmodule

`default_nettype wire

// ===== design/sync_length_frame_deframer.sv =====
// Sync/length framed byte stream deframer, top level.
// A result word goes through the result queue and then the output register to out_valid.
// Throughput: one byte per cycle; in_ready drops only while the result queue is full.
// Reset (rst, synchronous): hunting for sync, queue empty, out_valid low, max_body_len 260.
// Depends on sldf_pkg, sldf_front, sldf_queue, sldf_back.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_deframer #(
  parameter int QUEUE_DEPTH = sldf_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_end,
  output logic [7:0]       payload_byte,
  output logic [7:0]       command,
  output logic [7:0]       sequence_res,
  output logic [1:0]       status,
  output logic [15:0]      payload_count
);

  logic                  byte_we;
  logic                  push;
  logic                  pop;
  sldf_pkg::item_t       front_item;
  sldf_pkg::item_t       q_item;
  sldf_pkg::item_t       out_item;
  sldf_pkg::queue_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign byte_we   = in_valid && in_ready;

  sldf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .byte_we  (byte_we),
    .in_byte  (in_byte),
    .push     (push),
    .item     (front_item)
  );

  sldf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  sldf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign is_end        = out_item.is_end;
  assign payload_byte  = out_item.payload_byte;
  assign command       = out_item.command;
  assign sequence_res  = out_item.sequence_res;
  assign status        = out_item.status;
  assign payload_count = out_item.payload_count;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("result queue underflow");

  a_payload_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_end) |-> (status == sldf_pkg::ST_OK && payload_count == 16'd0))
    else $error("payload word carries verdict fields");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
